// ===== src/product_quantization_encoder_macros.svh =====
// assertion macros shared by the checker
`ifndef PRODUCT_QUANTIZATION_ENCODER_MACROS_SVH
`define PRODUCT_QUANTIZATION_ENCODER_MACROS_SVH

// property checked outside reset
`define PQE_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("pqe check failed");

// property checked at every edge, reset included
`define PQE_ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("pqe reset check failed");

`endif

// ===== src/pqe_pkg.sv =====
package pqe_pkg;

   localparam int MAX_SUB_DIMS  = 8;
   localparam int MAX_SUBSPACES = 64;
   localparam int NUM_CODES     = 256;

   localparam int VAL_W  = 16;
   localparam int DIMS_W = 4;
   localparam int ELEM_W = $clog2(MAX_SUB_DIMS);
   localparam int CODE_W = $clog2(NUM_CODES);
   localparam int SP_W   = $clog2(MAX_SUBSPACES);
   localparam int MAG_W  = VAL_W;
   localparam int SQ_W   = 2 * MAG_W;
   localparam int DIST_W = SQ_W + $clog2(MAX_SUB_DIMS);

   localparam int CB_DEPTH = MAX_SUBSPACES * NUM_CODES * MAX_SUB_DIMS;
   localparam int CB_AW    = SP_W + CODE_W + ELEM_W;

   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 16;

   localparam logic [DIMS_W-1:0] SUB_DIMS_RESET = 4'd2;

   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_SAMPLE = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SEARCH = 3'b010,
      ST_WAIT   = 3'b100
   } pqe_state_type;

   // tag that follows one codebook read down the distance pipeline
   typedef struct packed {
      logic              valid;
      logic              last_elem;
      logic [CODE_W-1:0] code;
   } pqe_tag_type;

   // outcome of a finished search
   typedef struct packed {
      logic              done;
      logic [CODE_W-1:0] code;
   } pqe_best_type;

endpackage

// ===== src/pqe_dist.sv =====
module pqe_dist import pqe_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic [VAL_W-1:0]   cb_data,
   input  logic [VAL_W-1:0]   sv_data,
   input  pqe_tag_type        tag,
   output pqe_best_type       best
);

   logic signed [VAL_W:0]  diff;
   logic [VAL_W:0]         diff_abs;
   logic [MAG_W-1:0]       mag_in;
   logic [MAG_W-1:0]       mag_ff;
   logic [SQ_W-1:0]        sq_in;
   logic [SQ_W-1:0]        sq_ff;
   logic [DIST_W-1:0]      sum;
   logic [DIST_W-1:0]      acc_in;
   logic [DIST_W-1:0]      acc_ff;
   logic [DIST_W-1:0]      best_dist_in;
   logic [DIST_W-1:0]      best_dist_ff;
   logic [CODE_W-1:0]      best_code_in;
   logic [CODE_W-1:0]      best_code_ff;
   logic                   done_in;
   logic                   done_ff;
   pqe_tag_type            tag2_ff;
   pqe_tag_type            tag3_ff;

   // difference magnitude always fits the element width
   always_comb begin
      diff     = $signed({sv_data[VAL_W-1], sv_data}) - $signed({cb_data[VAL_W-1], cb_data});
      diff_abs = diff[VAL_W] ? (~diff + 1'b1) : diff;
      mag_in   = diff_abs[MAG_W-1:0];
      sq_in    = mag_ff * mag_ff;
   end

   always_comb begin
      sum          = acc_ff + DIST_W'(sq_ff);
      acc_in       = acc_ff;
      best_dist_in = best_dist_ff;
      best_code_in = best_code_ff;
      done_in      = 1'b0;
      if (tag3_ff.valid) begin
         if (tag3_ff.last_elem) begin
            acc_in = '0;
            // first codeword always taken, later ones only when strictly closer
            if (tag3_ff.code == '0 || sum < best_dist_ff) begin
               best_dist_in = sum;
               best_code_in = tag3_ff.code;
            end
            done_in = (tag3_ff.code == CODE_W'(NUM_CODES - 1));
         end else begin
            acc_in = sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag2_ff <= '0;
         tag3_ff <= '0;
         acc_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         tag2_ff <= tag;
         tag3_ff <= tag2_ff;
         acc_ff  <= acc_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff       <= mag_in;
      sq_ff        <= sq_in;
      best_dist_ff <= best_dist_in;
      best_code_ff <= best_code_in;
   end

   assign best.done = done_ff;
   assign best.code = best_code_ff;

endmodule

// ===== src/product_quantization_encoder.sv =====
// product quantisation encoder: load beats (tuser opcode 0) write one 16-bit codeword element
// into the codebook memory; sample beats (opcode 1) gather sub_dims elements
// into a subvector, and the beat that completes a subvector starts a search over the 256
// codewords of the current subspace that emits the index of the nearest one (lowest index on
// a tie). the search is paced by the single read port of the
// codebook memory, which feeds one squared difference into the accumulator per cycle; no beat
// is taken during a search. the codebook has no reset and must be loaded before use. a
// partial subvector at tlast is dropped. the result register lets the next beats in while a
// code waits to be taken
module product_quantization_encoder import pqe_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   // request stream
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // [5:0] subspace, [13:6] center_index, [16:14] element_index, [32:17] value, rest zero
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // [0] opcode
   input  logic [0:0]             req_tuser,
   input  logic                   req_tlast,
   // response stream
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [7:0] code, [13:8] code_subspace, rest zero
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic                   rsp_tlast,
   // sub_dims register write
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [DIMS_W-1:0]      csr_data
);

   // codebook memory, addressed as subspace, codeword, element
   logic [VAL_W-1:0]   cb_mem [CB_DEPTH];
   logic [VAL_W-1:0]   cb_rd_ff;
   logic               cb_we;
   logic [CB_AW-1:0]   cb_waddr;
   logic [CB_AW-1:0]   cb_raddr;

   // subvector being collected
   logic [VAL_W-1:0]   sv_ff [MAX_SUB_DIMS];
   logic [VAL_W-1:0]   sv_rd_ff;

   pqe_state_type      state_ff, state_in;
   logic [DIMS_W-1:0]  sub_dims_ff, sub_dims_in;
   logic [ELEM_W-1:0]  ec_ff, ec_in;
   logic [SP_W-1:0]    sp_cnt_ff, sp_cnt_in;
   logic               issue_ff, issue_in;
   logic [CODE_W-1:0]  code_ff, code_in;
   logic [ELEM_W-1:0]  elem_ff, elem_in;
   logic [ELEM_W-1:0]  dims_m1_ff, dims_m1_in;
   logic [SP_W-1:0]    cs_ff, cs_in;
   logic               last_ff, last_in;
   logic [CODE_W-1:0]  res_code_ff, res_code_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [CODE_W-1:0]  rsp_code_ff;
   logic [SP_W-1:0]    rsp_sp_ff;
   logic               rsp_last_ff;
   pqe_tag_type        tag1_ff, tag1_in;
   pqe_best_type       best;

   logic               req_fire;
   logic               is_load;
   logic               is_sample;
   logic               complete;
   logic               rsp_load;
   logic               elem_wrap;
   logic [DIMS_W-1:0]  dims_eff;
   logic [DIMS_W-1:0]  ec_inc;
   logic [SP_W-1:0]    f_subspace;
   logic [CODE_W-1:0]  f_center;
   logic [ELEM_W-1:0]  f_element;
   logic [VAL_W-1:0]   f_value;

   // beat fields
   assign f_subspace = req_tdata[SP_W-1:0];
   assign f_center   = req_tdata[SP_W+CODE_W-1:SP_W];
   assign f_element  = req_tdata[SP_W+CODE_W+ELEM_W-1:SP_W+CODE_W];
   assign f_value    = req_tdata[SP_W+CODE_W+ELEM_W+VAL_W-1:SP_W+CODE_W+ELEM_W];

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign req_fire   = req_tvalid && req_tready;
   assign is_load    = req_fire && (req_tuser[0] == OP_LOAD);
   assign is_sample  = req_fire && (req_tuser[0] == OP_SAMPLE);

   // zero acts as one, anything above the maximum acts as the maximum
   always_comb begin
      if (sub_dims_ff == '0) begin
         dims_eff = DIMS_W'(1);
      end else if (sub_dims_ff > DIMS_W'(MAX_SUB_DIMS)) begin
         dims_eff = DIMS_W'(MAX_SUB_DIMS);
      end else begin
         dims_eff = sub_dims_ff;
      end
   end

   assign ec_inc    = DIMS_W'(ec_ff) + DIMS_W'(1);
   assign complete  = is_sample && (ec_inc >= dims_eff);
   assign rsp_load  = (state_ff == ST_WAIT) && (!rsp_valid_ff || rsp_tready);
   assign elem_wrap = (elem_ff == dims_m1_ff);

   // collection counters and search set-up
   always_comb begin
      sub_dims_in = csr_valid ? csr_data : sub_dims_ff;
      ec_in       = ec_ff;
      sp_cnt_in   = sp_cnt_ff;
      dims_m1_in  = dims_m1_ff;
      cs_in       = cs_ff;
      last_in     = last_ff;
      if (is_sample) begin
         if (complete) begin
            ec_in      = '0;
            dims_m1_in = ELEM_W'(dims_eff - DIMS_W'(1));
            cs_in      = sp_cnt_ff;
            last_in    = req_tlast;
            // subspace count sticks at the top without tlast
            if (req_tlast) begin
               sp_cnt_in = '0;
            end else if (sp_cnt_ff != SP_W'(MAX_SUBSPACES - 1)) begin
               sp_cnt_in = sp_cnt_ff + SP_W'(1);
            end
         end else if (req_tlast) begin
            // partial subvector dropped
            ec_in     = '0;
            sp_cnt_in = '0;
         end else begin
            ec_in = ec_ff + ELEM_W'(1);
         end
      end
   end

   // read sequencer: every element of every codeword in turn
   always_comb begin
      issue_in = issue_ff;
      code_in  = code_ff;
      elem_in  = elem_ff;
      if (complete) begin
         issue_in = 1'b1;
         code_in  = '0;
         elem_in  = '0;
      end else if (issue_ff) begin
         if (elem_wrap) begin
            elem_in = '0;
            if (code_ff == CODE_W'(NUM_CODES - 1)) begin
               issue_in = 1'b0;
            end else begin
               code_in = code_ff + CODE_W'(1);
            end
         end else begin
            elem_in = elem_ff + ELEM_W'(1);
         end
      end
      tag1_in.valid     = (state_ff == ST_SEARCH) && issue_ff;
      tag1_in.last_elem = elem_wrap;
      tag1_in.code      = code_ff;
   end

   always_comb begin
      state_in    = state_ff;
      res_code_in = res_code_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (complete) begin
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (best.done) begin
               state_in    = ST_WAIT;
               res_code_in = best.code;
            end
         end
         ST_WAIT: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sub_dims_ff  <= SUB_DIMS_RESET;
         ec_ff        <= '0;
         sp_cnt_ff    <= '0;
         issue_ff     <= 1'b0;
         tag1_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sub_dims_ff  <= sub_dims_in;
         ec_ff        <= ec_in;
         sp_cnt_ff    <= sp_cnt_in;
         issue_ff     <= issue_in;
         tag1_ff      <= tag1_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // search payload and result register
   always_ff @(posedge clock) begin
      code_ff     <= code_in;
      elem_ff     <= elem_in;
      dims_m1_ff  <= dims_m1_in;
      cs_ff       <= cs_in;
      last_ff     <= last_in;
      res_code_ff <= res_code_in;
      if (rsp_load) begin
         rsp_code_ff <= res_code_ff;
         rsp_sp_ff   <= cs_ff;
         rsp_last_ff <= last_ff;
      end
   end

   // subvector store, read in step with the codebook
   always_ff @(posedge clock) begin
      if (is_sample) begin
         sv_ff[ec_ff] <= f_value;
      end
      sv_rd_ff <= sv_ff[elem_ff];
   end

   assign cb_we    = is_load;
   assign cb_waddr = {f_subspace, f_center, f_element};
   assign cb_raddr = {cs_ff, code_ff, elem_ff};

   // no beat is taken during a search, so writes and reads never overlap
   always_ff @(posedge clock) begin
      if (cb_we) begin
         cb_mem[cb_waddr] <= f_value;
      end
      cb_rd_ff <= cb_mem[cb_raddr];
   end

   pqe_dist u_dist (
      .clock   (clock),
      .reset   (reset),
      .cb_data (cb_rd_ff),
      .sv_data (sv_rd_ff),
      .tag     (tag1_ff),
      .best    (best)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_TDATA_W - SP_W - CODE_W)'(0), rsp_sp_ff, rsp_code_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== src/pqe_checker.sv =====
`include "product_quantization_encoder_macros.svh"

module pqe_checker import pqe_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata,
   input logic                   rsp_tlast
);

   // a stalled code holds
   `PQE_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))

   // no code straight out of reset
   `PQE_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_tvalid)

   // a code is loaded only while the block takes no beats, so an accepted beat never shows a code at once
   `PQE_ASSERT(a_no_instant_code, req_tvalid && req_tready && !rsp_tvalid |=> !rsp_tvalid)

   // a new code appears only as the block goes back to taking beats
   `PQE_ASSERT(a_code_frees_req, $rose(rsp_tvalid) |-> req_tready)

   // padding above the packed fields stays clear
   `PQE_ASSERT(a_rsp_pad, rsp_tvalid |-> rsp_tdata[RSP_TDATA_W-1:SP_W+CODE_W] == '0)

endmodule

bind product_quantization_encoder pqe_checker u_pqe_checker (.*);
